@@ hw/rtl/wfd_pkg.sv @@
// Shared types and constants for the weather frame decoder.
// Used by wfd_capture, wfd_convert and weather_frame_decoder; no dependencies.
`default_nettype none

package wfd_pkg;

    // Frame layout
    localparam int FrameBytes  = 25;
    localparam int DigestFirst = 2;
    localparam int CountBits   = $clog2(FrameBytes + 1);

    // Configuration port
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 16;

    // Register reset values
    localparam logic [7:0]  WhiteningMaskReset = 8'hAA;
    localparam logic [15:0] GeneratorReset     = 16'h8810;
    localparam logic [15:0] KeyStartReset      = 16'hBA95;
    localparam logic [15:0] FinalXorReset      = 16'h6DF1;
    localparam logic [15:0] TypeMaskReset      = 16'h011A;

    // Stream widths
    localparam int InDataBits  = 16;
    localparam int OutDataBits = 128;

    typedef enum logic [CfgIndexBits-1:0] {
        REG_WHITENING_MASK = 3'd0,
        REG_GENERATOR      = 3'd1,
        REG_KEY_START      = 3'd2,
        REG_FINAL_XOR      = 3'd3,
        REG_TYPE_MASK      = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_DECODED     = 2'd0,
        STATUS_SHORT       = 2'd1,
        STATUS_MISMATCH    = 2'd2,
        STATUS_NOT_WEATHER = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] generator;
        logic [15:0] key_start;
        logic [15:0] final_xor;
        logic [15:0] type_mask;
    } cfg_t;

    // One received byte after de-whitening.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic [7:0] rssi_code;
    } item_t;

    // Copy of a finished frame, handed from capture to conversion.
    typedef struct packed {
        status_t                     status;
        logic [7:0]                  rssi_code;
        logic [FrameBytes-1:0][7:0]  bytes;
    } snap_t;

endpackage

`default_nettype wire

@@ hw/rtl/wfd_capture.sv @@
// Frame capture: byte store, byte counter and LFSR digest for one frame.
// Depends on wfd_pkg.
`default_nettype none

module wfd_capture
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wfd_pkg::cfg_t  cfg,
    input  wire logic          step,
    input  wire wfd_pkg::item_t item,
    output wfd_pkg::snap_t      snap
);
    import wfd_pkg::*;

    logic [CountBits-1:0]       count_reg, count_next;
    logic [15:0]                sum_reg, sum_next;
    logic [15:0]                key_reg, key_next;
    logic [FrameBytes-1:0][7:0] payload_reg, payload_next;
    snap_t                      snap_reg, snap_next;

    logic        take;
    logic        in_digest;
    logic [15:0] key_in, sum_in, key_d, sum_d, sum_after;
    logic [CountBits-1:0] count_after;
    logic [15:0] chk;

    assign take      = step && (count_reg < CountBits'(FrameBytes));
    assign in_digest = take && (count_reg >= CountBits'(DigestFirst));

    // The key is reloaded as the first digested byte arrives.
    assign key_in = (count_reg == CountBits'(DigestFirst)) ? cfg.key_start : key_reg;
    assign sum_in = (count_reg == CountBits'(DigestFirst)) ? 16'd0 : sum_reg;

    // Eight bit steps of the digest, most significant data bit first.
    always_comb
    begin
        logic [15:0] k;
        logic [15:0] s;
        k = key_in;
        s = sum_in;
        for (int i = 0; i < 8; i++)
        begin
            if (item.data_byte[3'(7 - i)])
            begin
                s = s ^ k;
            end
            if (k[0])
            begin
                k = (k >> 1) ^ cfg.generator;
            end
            else
            begin
                k = k >> 1;
            end
        end
        key_d = k;
        sum_d = s;
    end

    always_comb
    begin
        payload_next = payload_reg;
        if (take)
        begin
            payload_next[count_reg] = item.data_byte;
        end
    end

    assign count_after = take ? CountBits'(count_reg + 1'b1) : count_reg;
    assign sum_after   = in_digest ? sum_d : sum_reg;
    assign chk         = {payload_next[0], payload_next[1]};

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        key_next   = key_reg;
        if (step && item.frame_end)
        begin
            count_next = '0;
            sum_next   = '0;
            key_next   = cfg.key_start;
        end
        else if (step)
        begin
            count_next = count_after;
            if (in_digest)
            begin
                sum_next = sum_d;
                key_next = key_d;
            end
        end
    end

    always_comb
    begin
        snap_next           = snap_reg;
        snap_next.rssi_code = item.rssi_code;
        snap_next.bytes     = payload_next;
        if (count_after != CountBits'(FrameBytes))
        begin
            snap_next.status = STATUS_SHORT;
        end
        else if ((chk ^ sum_after) != cfg.final_xor)
        begin
            snap_next.status = STATUS_MISMATCH;
        end
        else
        begin
            snap_next.status = STATUS_DECODED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            key_reg   <= KeyStartReset;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            key_reg   <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        if (step && item.frame_end)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap = snap_reg;

endmodule

`default_nettype wire

@@ hw/rtl/wfd_convert.sv @@
// Result conversion: BCD to binary, sign handling, scaling and packing.
// Depends on wfd_pkg.
`default_nettype none

module wfd_convert
(
    input  wire logic                           clk,
    input  wire wfd_pkg::cfg_t                   cfg,
    input  wire logic                           load,
    input  wire wfd_pkg::snap_t                  snap,
    output logic [wfd_pkg::OutDataBits-1:0]     data,
    output wfd_pkg::status_t                     status
);
    import wfd_pkg::*;

    // A nibble above nine reads as nine.
    function automatic logic [3:0] bcd_digit(input logic [3:0] n);
        return (n > 4'd9) ? 4'd9 : n;
    endfunction

    function automatic logic [9:0] bcd3(input logic [3:0] d2, input logic [3:0] d1,
                                        input logic [3:0] d0);
        return 10'(bcd_digit(d2)) * 10'd100 + 10'(bcd_digit(d1)) * 10'd10
             + 10'(bcd_digit(d0));
    endfunction

    function automatic logic [19:0] bcd6(input logic [7:0] b2, input logic [7:0] b1,
                                         input logic [7:0] b0);
        return 20'(bcd_digit(b2[7:4])) * 20'd100000 + 20'(bcd_digit(b2[3:0])) * 20'd10000
             + 20'(bcd_digit(b1[7:4])) * 20'd1000   + 20'(bcd_digit(b1[3:0])) * 20'd100
             + 20'(bcd_digit(b0[7:4])) * 20'd10     + 20'(bcd_digit(b0[3:0]));
    endfunction

    logic [OutDataBits-1:0] data_reg, data_next;
    status_t                status_reg, status_next;

    logic [3:0]         stype;
    logic               decoded, id_valid;
    logic [15:0]        station_id;
    logic [9:0]         wdir, wind_raw, temp_bcd, uv;
    logic [15:0]        wind;
    logic signed [10:0] temp;
    logic [6:0]         hum;
    logic [19:0]        rain, lux;
    logic signed [7:0]  rssi_v;
    logic signed [8:0]  rssi;

    assign stype    = snap.bytes[6][7:4];
    assign id_valid = (snap.status == STATUS_DECODED);
    assign decoded  = id_valid && cfg.type_mask[stype];

    assign station_id = {snap.bytes[2], snap.bytes[3]};
    assign wdir      = bcd3(snap.bytes[4][7:4], snap.bytes[4][3:0], snap.bytes[5][7:4]);
    assign wind_raw  = bcd3(snap.bytes[8][3:0], snap.bytes[9][7:4], snap.bytes[9][3:0]);
    assign wind      = 16'(wind_raw) * 16'd36;
    assign temp_bcd  = bcd3(snap.bytes[14][7:4], snap.bytes[14][3:0], snap.bytes[15][7:4]);
    assign temp      = (temp_bcd > 10'd600) ? $signed(11'(temp_bcd) - 11'd1000)
                                            : $signed(11'(temp_bcd));
    assign hum       = 7'(bcd_digit(snap.bytes[16][7:4])) * 7'd10
                     + 7'(bcd_digit(snap.bytes[16][3:0]));
    assign rain      = bcd6(snap.bytes[10], snap.bytes[11], snap.bytes[12]);
    assign lux       = bcd6(snap.bytes[17], snap.bytes[18], snap.bytes[19]);
    assign uv        = bcd3(snap.bytes[20][7:4], snap.bytes[20][3:0], snap.bytes[21][7:4]);

    // Halve towards zero: an odd negative value needs one added after the shift.
    assign rssi_v = $signed(snap.rssi_code);
    assign rssi   = 9'(rssi_v >>> 1) + 9'({1'b0, snap.rssi_code[7] & snap.rssi_code[0]})
                  - 9'sd74;

    always_comb
    begin
        data_next = '0;
        if (id_valid)
        begin
            data_next[15:0]  = station_id;
            data_next[19:16] = stype;
            data_next[22:20] = snap.bytes[6][2:0];
        end
        if (decoded)
        begin
            data_next[32:23]   = wdir;
            data_next[48:33]   = wind;
            data_next[59:49]   = temp;
            data_next[66:60]   = hum;
            data_next[86:67]   = rain;
            data_next[106:87]  = lux;
            data_next[116:107] = uv;
        end
        data_next[125:117] = rssi;

        status_next = snap.status;
        if (id_valid && !decoded)
        begin
            status_next = STATUS_NOT_WEATHER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign data   = data_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

@@ hw/rtl/weather_frame_decoder.sv @@
// Top level of the weather frame decoder: stream ports, configuration registers,
// handshake control. Depends on wfd_pkg, wfd_capture and wfd_convert.
`default_nettype none

// The decoder takes one whitened radio byte per transfer on the slave stream and
// may take a new byte in every clock cycle unless a frame end waits for the
// snapshot register. Each byte passes an input register, then the capture stage
// (byte store, counter and the digest, whose eight LFSR bit steps form one
// combinational byte step), then a frame snapshot register, then the conversion
// stage into the output register. A byte marked with tlast ends the frame and
// yields exactly one result transfer; other bytes yield nothing. Only the first
// 25 bytes of a frame are kept; later ones are ignored. The result carries
// decode_status in tuser: decoded, frame too short, digest mismatch, or a sensor
// type not set in the accepted type mask. On a short frame or a mismatch every
// data field except the RSSI is zero; on an unaccepted type the sensor id, type
// and channel are given and the measurements are zero. Back-pressure on the
// master side propagates stage by stage, so bytes that do not end a frame keep
// flowing while a result waits. Configuration registers should only be written
// while no frame is in flight; the digest key start is taken when byte 2 of a
// frame arrives.
module weather_frame_decoder
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Configuration write port
    input  wire logic                               cfg_wen,
    input  wire logic [wfd_pkg::CfgIndexBits-1:0]   cfg_index,
    input  wire logic [wfd_pkg::CfgDataBits-1:0]    cfg_data,

    // Received bytes
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata, from bit 0: data_byte[7:0], rssi_code[15:8]
    input  wire logic [wfd_pkg::InDataBits-1:0]     s_tdata,
    input  wire logic                               s_tlast,   // frame_end

    // Decoded results
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata, from bit 0: station_id[15:0], sensor_type[19:16],
    // radio_channel[22:20], wind_direction_deg[32:23],
    // wind_speed_centi_kmh[48:33], temperature_deci_c[59:49],
    // humidity[66:60], rain_deci_mm[86:67], illuminance[106:87],
    // uv_deci_index[116:107], signal_dbm[125:117], zero padding[127:126]
    output logic [wfd_pkg::OutDataBits-1:0]         m_tdata,
    // m_tuser, from bit 0: decode_status[1:0]
    output logic [1:0]                              m_tuser
);
    import wfd_pkg::*;

    // Configuration registers
    logic [7:0] mask_reg, mask_next;
    cfg_t       cfg_reg, cfg_next;

    always_comb
    begin
        mask_next = mask_reg;
        cfg_next  = cfg_reg;
        if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WHITENING_MASK: mask_next          = cfg_data[7:0];
                REG_GENERATOR:      cfg_next.generator = cfg_data;
                REG_KEY_START:      cfg_next.key_start = cfg_data;
                REG_FINAL_XOR:      cfg_next.final_xor = cfg_data;
                REG_TYPE_MASK:      cfg_next.type_mask = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg          <= WhiteningMaskReset;
            cfg_reg.generator <= GeneratorReset;
            cfg_reg.key_start <= KeyStartReset;
            cfg_reg.final_xor <= FinalXorReset;
            cfg_reg.type_mask <= TypeMaskReset;
        end
        else
        begin
            mask_reg <= mask_next;
            cfg_reg  <= cfg_next;
        end
    end

    // Pipeline control. Each stage moves on when the stage after it is empty or
    // is being emptied in the same cycle; only a frame end waits on the snapshot.
    logic  in_valid_reg, in_valid_next;
    logic  snap_valid_reg, snap_valid_next;
    logic  out_valid_reg, out_valid_next;
    item_t item_reg;

    logic  out_free, snap_free, capture_go, snap_load, snap_take;

    assign out_free   = !out_valid_reg || m_tready;
    assign snap_free  = !snap_valid_reg || out_free;
    // A byte that does not end a frame never needs the snapshot register.
    assign capture_go = in_valid_reg && (!item_reg.frame_end || snap_free);
    assign snap_load  = capture_go && item_reg.frame_end;
    assign snap_take  = snap_valid_reg && out_free;
    assign s_tready   = !in_valid_reg || capture_go;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end

        snap_valid_next = snap_valid_reg;
        if (snap_load)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (snap_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input register; the whitening is removed on the way in.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte <= s_tdata[7:0] ^ mask_reg;
            item_reg.frame_end <= s_tlast;
            item_reg.rssi_code <= s_tdata[15:8];
        end
    end

    snap_t   snap;
    status_t status;

    wfd_capture u_capture
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (capture_go),
        .item  (item_reg),
        .snap  (snap)
    );

    wfd_convert u_convert
    (
        .clk    (clk),
        .cfg    (cfg_reg),
        .load   (snap_take),
        .snap   (snap),
        .data   (m_tdata),
        .status (status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status;

`ifndef SYNTHESIS
    // The input register only holds back when it carries an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled while empty");

    // A frame end that leaves capture is always waiting in the snapshot next.
    assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> snap_valid_reg)
        else $error("frame end lost between capture and snapshot");

    // Rejected frames carry no sensor identity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_SHORT || m_tuser == STATUS_MISMATCH))
            |-> (m_tdata[22:0] == 23'd0))
        else $error("rejected frame carries sensor fields");

    // A result only appears after a snapshot was handed over.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(snap_valid_reg))
        else $error("result without a captured frame");
`endif

endmodule

`default_nettype wire
